/* rtl/assert_macros.svh */
// Assertion macros used by the checker in rcl_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/rcl_pkg.sv */
package rcl_pkg;

    // Window length in bytes; it must hold the longest keyword.
    localparam int KEY_WINDOW = 12;
    localparam int NUM_KEYS   = 10;
    localparam int BYTE_W     = 8;
    localparam int KW_BITS    = KEY_WINDOW * BYTE_W;

    localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    // Response codes given for a line.
    typedef enum logic [3:0] {
        RC_OK           = 4'd0,
        RC_CONNECT      = 4'd1,
        RC_BUSY         = 4'd2,
        RC_ERROR        = 4'd3,
        RC_AT_ECHO      = 4'd4,
        RC_EMPTY        = 4'd5,
        RC_SEND_HOST    = 4'd6,
        RC_SEND_LINK    = 4'd7,
        RC_PROMPT       = 4'd8,
        RC_CLOSED       = 4'd9,
        RC_READ_SENSOR  = 4'd10,
        RC_UNKNOWN      = 4'd11
    } t_resp_code;

    // Window contents, element 0 is the newest byte.
    typedef logic [KEY_WINDOW-1:0][BYTE_W-1:0] t_window;

    // Control handed from the line logic to the window cells.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // Keywords in priority order. A string literal keeps its last character
    // in the lowest byte, which lines up with the newest window byte.
    localparam logic [KW_BITS-1:0] KEY_TEXT [NUM_KEYS] = '{
        KW_BITS'("CONNECT"),
        KW_BITS'("OK"),
        KW_BITS'("ERROR"),
        KW_BITS'("busy"),
        KW_BITS'("AT"),
        KW_BITS'({"SEND_FROM", "_PC"}),
        KW_BITS'({"CIPSEND", "_PC"}),
        KW_BITS'(">"),
        KW_BITS'("CLOSED"),
        KW_BITS'({"READ_BME", "280"})
    };

    localparam int KEY_LEN [NUM_KEYS] = '{7, 2, 5, 4, 2, 12, 10, 1, 6, 11};

    localparam t_resp_code KEY_CODE [NUM_KEYS] = '{
        RC_CONNECT, RC_OK, RC_ERROR, RC_BUSY, RC_AT_ECHO,
        RC_SEND_HOST, RC_SEND_LINK, RC_PROMPT, RC_CLOSED, RC_READ_SENSOR
    };

    // The first found keyword in priority order gives the code.
    function automatic t_resp_code classify(logic [NUM_KEYS-1:0] found, logic nonempty);
        t_resp_code code;
        code = nonempty ? RC_UNKNOWN : RC_EMPTY;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (found[k]) begin
                code = KEY_CODE[k];
            end
        end
        return code;
    endfunction

endpackage

/* rtl/rcl_cell.sv */
module rcl_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rcl_pkg::t_cell_ctl        i_ctl,
    input  logic [rcl_pkg::BYTE_W-1:0] i_d,
    output logic [rcl_pkg::BYTE_W-1:0] o_q
);
    import rcl_pkg::*;

    logic [BYTE_W-1:0] r_byte;

    // One window byte: cleared at line start, loaded from i_d on a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= ZERO_BYTE;
        end else if (i_ctl.clear) begin
            r_byte <= ZERO_BYTE;
        end else if (i_ctl.shift) begin
            r_byte <= i_d;
        end
    end

    assign o_q = r_byte;

endmodule

/* rtl/rcl_match.sv */
module rcl_match (
    input  rcl_pkg::t_window             i_win,
    output logic [rcl_pkg::NUM_KEYS-1:0] o_hit
);
    import rcl_pkg::*;

    // A keyword hits when it ends at the newest byte of the window.
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            o_hit[k] = (KEY_LEN[k] <= KEY_WINDOW);
            for (int i = 0; i < KEY_WINDOW; i++) begin
                if (i < KEY_LEN[k] && i_win[i] != KEY_TEXT[k][i*BYTE_W +: BYTE_W]) begin
                    o_hit[k] = 1'b0;
                end
            end
        end
    end

endmodule

/* rtl/at_response_line_classifier.sv */
// Classifies the text lines of a modem receive buffer. Bytes enter one per
// word on the slave side, tlast marking the final byte of the buffer; one
// byte is taken every clock cycle while the output register is free or being
// emptied, and a result appears in the cycle after the byte that causes it.
// Each result word carries the response code in tdata[3:0] and, in tlast,
// whether it is the last line of the buffer. A result is given at every newline
// before a zero byte ends the text, and at buffer end for a non-empty open line.
// The recent line bytes sit in a row of window cells that shift by one per stored
// byte, and keyword hits against that window are kept as sticky flags per line.
module at_response_line_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic       i_s_tlast,   // buffer_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [3:0] response_code, [7:4] zero
    output logic       o_m_tlast    // last_line
);
    import rcl_pkg::*;

    t_window               w_win;
    t_window               n_win;
    t_cell_ctl             w_ctl;
    logic [NUM_KEYS-1:0]   w_hit;

    logic [NUM_KEYS-1:0]   r_found, n_found;
    logic                  r_nonempty, n_nonempty;
    logic                  r_started, n_started;
    logic                  r_stopped, n_stopped;
    logic                  r_valid, n_valid;
    t_resp_code            r_code, n_code;
    logic                  r_last, n_last;

    logic                  w_acc, w_active, w_push, w_nl;
    logic [NUM_KEYS-1:0]   w_found_now;
    logic                  w_nonempty_now;

    // Input is taken whenever the output register is free or drains this cycle.
    assign o_s_tready = !r_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_active   = !r_stopped;
    assign w_nl       = w_acc && w_active && (i_s_tdata == NEWLINE);
    assign w_push     = w_acc && w_active && (i_s_tdata != ZERO_BYTE)
                        && (i_s_tdata != NEWLINE);

    // Window as it stands after a shift, for the keyword compare.
    always_comb begin
        n_win[0] = i_s_tdata;
        for (int i = 1; i < KEY_WINDOW; i++) begin
            n_win[i] = w_win[i-1];
        end
    end

    assign w_ctl.shift = w_push;
    assign w_ctl.clear = w_acc && (i_s_tlast || w_nl);

    // Row of window cells, each fed by its newer neighbor, the first by the input byte.
    for (genvar g = 0; g < KEY_WINDOW; g++) begin : g_cell
        rcl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_d     (n_win[g]),
            .o_q     (w_win[g])
        );
    end

    rcl_match u_match (
        .i_win (n_win),
        .o_hit (w_hit)
    );

    // Line state as seen after this byte, and the result it causes.
    always_comb begin
        w_found_now    = w_push ? (r_found | w_hit) : r_found;
        w_nonempty_now = w_push ? 1'b1 : r_nonempty;

        n_found    = r_found;
        n_nonempty = r_nonempty;
        n_started  = r_started;
        n_stopped  = r_stopped;
        n_valid    = r_valid && !i_m_tready;
        n_code     = r_code;
        n_last     = r_last;

        if (o_s_tready) begin
            n_valid = w_nl || (w_acc && i_s_tlast && w_nonempty_now);
            n_code  = classify(w_found_now, w_nonempty_now);
            n_last  = i_s_tlast;
        end

        if (w_acc) begin
            if (w_active) begin
                if (i_s_tdata == ZERO_BYTE) begin
                    n_stopped = r_started;
                end else begin
                    n_started = 1'b1;
                end
            end
            if (w_nl) begin
                n_found    = '0;
                n_nonempty = 1'b0;
            end else if (w_push) begin
                n_found    = w_found_now;
                n_nonempty = 1'b1;
            end
            if (i_s_tlast) begin
                n_found    = '0;
                n_nonempty = 1'b0;
                n_started  = 1'b0;
                n_stopped  = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= '0;
            r_nonempty <= 1'b0;
            r_started  <= 1'b0;
            r_stopped  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_found    <= n_found;
            r_nonempty <= n_nonempty;
            r_started  <= n_started;
            r_stopped  <= n_stopped;
            r_valid    <= n_valid;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_last <= n_last;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {4'b0000, r_code};
    assign o_m_tlast  = r_last;

endmodule

/* rtl/rcl_checker.sv */
`include "assert_macros.svh"

module rcl_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       o_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] o_m_tdata,
    input  logic       o_m_tlast
);

    logic w_stall;
    logic w_in_acc;
    logic w_code_ok;

    assign w_stall   = o_m_tvalid && !i_m_tready;
    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_code_ok = (o_m_tdata[7:4] == 4'd0) && (o_m_tdata[3:0] <= 4'd11);

    // A stalled result word stays offered and unchanged.
    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, w_stall, o_m_tvalid)
    `ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, w_stall, $stable(o_m_tdata) && $stable(o_m_tlast))
    // An empty output register never holds back the input.
    `ASSERT_IMPLIES(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)
    // A new result only follows an accepted byte, and its code is a defined one.
    `ASSERT_IMPLIES(a_result_cause, i_clk, i_rst_n, $rose(o_m_tvalid), $past(w_in_acc) && w_code_ok)

endmodule

bind at_response_line_classifier rcl_checker u_rcl_checker (.*);

/* tb/at_response_line_checker.sv */
// Watches both word channels of the line classifier, keeps its own model of
// the line state, and compares every result word with the oldest expected one.
module at_response_line_checker
    import rcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic       i_s_tlast,   // buffer_end
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [3:0] response_code, [7:4] zero
    input  logic       i_m_tlast,   // last_line
    output int         o_mismatch_count,
    output int         o_pending,
    output int         o_lines_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_LEN    = 12;
    localparam int KEYWORD_COUNT = 10;
    localparam int REPORT_LIMIT  = 20;

    typedef struct {
        t_resp_code code;
        logic       last_line;
    } t_line_result;

    string        keyword_text [KEYWORD_COUNT];
    t_resp_code   keyword_code [KEYWORD_COUNT];

    logic [7:0]               recent_bytes [WINDOW_LEN];  // element 0 is the newest
    logic [KEYWORD_COUNT-1:0] keyword_seen;
    logic                     line_has_bytes;
    logic                     text_begun;
    logic                     text_ended;
    t_line_result             expected_lines [$];

    // Keywords in priority order, each with the code that it gives.
    initial begin
        keyword_text[0] = "CONNECT";      keyword_code[0] = RC_CONNECT;
        keyword_text[1] = "OK";           keyword_code[1] = RC_OK;
        keyword_text[2] = "ERROR";        keyword_code[2] = RC_ERROR;
        keyword_text[3] = "busy";         keyword_code[3] = RC_BUSY;
        keyword_text[4] = "AT";           keyword_code[4] = RC_AT_ECHO;
        keyword_text[5] = {"SEND_FROM", "_PC"};
        keyword_code[5] = RC_SEND_HOST;
        keyword_text[6] = {"CIPSEND", "_PC"};
        keyword_code[6] = RC_SEND_LINK;
        keyword_text[7] = ">";            keyword_code[7] = RC_PROMPT;
        keyword_text[8] = "CLOSED";       keyword_code[8] = RC_CLOSED;
        keyword_text[9] = {"READ_BME", "280"};
        keyword_code[9] = RC_READ_SENSOR;
    end

    function automatic void forget_line();
        for (int i = 0; i < WINDOW_LEN; i++) begin
            recent_bytes[i] = 8'h00;
        end
        keyword_seen   = '0;
        line_has_bytes = 1'b0;
    endfunction

    // Shift a byte into the window and flag every keyword that now ends there.
    function automatic void shift_in(logic [7:0] value);
        int  len;
        bit  hit;
        for (int i = WINDOW_LEN - 1; i > 0; i--) begin
            recent_bytes[i] = recent_bytes[i-1];
        end
        recent_bytes[0] = value;
        line_has_bytes  = 1'b1;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            len = keyword_text[k].len();
            hit = (len <= WINDOW_LEN);
            for (int i = 0; hit && i < len; i++) begin
                if (keyword_text[k][len-1-i] != recent_bytes[i]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                keyword_seen[k] = 1'b1;
            end
        end
    endfunction

    function automatic t_resp_code line_code();
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (keyword_seen[k]) begin
                return keyword_code[k];
            end
        end
        return line_has_bytes ? RC_UNKNOWN : RC_EMPTY;
    endfunction

    // One accepted byte: update the line state and queue the result it causes.
    function automatic void take_byte(logic [7:0] value, logic buffer_end);
        t_line_result outcome;
        bit           emit;
        emit = 1'b0;
        if (!text_ended) begin
            if (value == ZERO_BYTE) begin
                if (text_begun) begin
                    text_ended = 1'b1;
                end
            end else begin
                text_begun = 1'b1;
                if (value == NEWLINE) begin
                    outcome.code = line_code();
                    emit = 1'b1;
                    forget_line();
                end else begin
                    shift_in(value);
                end
            end
        end
        // The final byte of a buffer closes a non-empty open line and resets all.
        if (buffer_end) begin
            if (!emit && line_has_bytes) begin
                outcome.code = line_code();
                emit = 1'b1;
            end
            forget_line();
            text_begun = 1'b0;
            text_ended = 1'b0;
        end
        if (emit) begin
            outcome.last_line = buffer_end;
            expected_lines.push_back(outcome);
        end
    endfunction

    // Compare result words first, then take the input word of the same edge.
    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            forget_line();
            text_begun = 1'b0;
            text_ended = 1'b0;
            expected_lines.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_lines_checked++;
                if (expected_lines.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= REPORT_LIMIT) begin
                        $display("%t: unexpected result word, tdata=%h tlast=%b",
                                 $realtime, i_m_tdata, i_m_tlast);
                    end
                end else begin
                    want = expected_lines.pop_front();
                    if (i_m_tdata !== {4'h0, want.code} || i_m_tlast !== want.last_line) begin
                        o_mismatch_count++;
                        if (o_mismatch_count <= REPORT_LIMIT) begin
                            $display("%t: expected code %0d last %b, got tdata %h last %b",
                                     $realtime, want.code, want.last_line,
                                     i_m_tdata, i_m_tlast);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                take_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = expected_lines.size();
    end

endmodule

/* tb/at_response_line_classifier_test.sv */
// Drives modem receive buffers into the line classifier under several idle and
// stall patterns; the checker beside the block does all the comparing.
module at_response_line_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rcl_pkg::*;

    localparam int BYTES_PER_PHASE = 440;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int KEYWORD_COUNT   = 10;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int mismatch_count;
    int pending_lines;
    int lines_checked;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int bytes_sent         = 0;
    int buffers_sent       = 0;
    int quiet_cycles       = 0;

    string      keyword_text [KEYWORD_COUNT];
    logic [7:0] buffer_bytes [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    at_response_line_classifier dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    at_response_line_checker line_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tlast        (s_tlast),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tlast        (m_tlast),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_lines),
        .o_lines_checked  (lines_checked)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: too long without any word moving on either side ends the run.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL at_response_line_classifier");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic buffer_end);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= buffer_end;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buffer_bytes.size(); i++) begin
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
        end
        buffers_sent++;
    endtask

    function automatic void add_text(string text);
        for (int i = 0; i < text.len(); i++) begin
            buffer_bytes.push_back(text[i]);
        end
    endfunction

    // A line body: keywords, near misses, printable text and raw bytes.
    function automatic void add_line_body();
        int    pieces;
        int    pick;
        string word;
        logic [7:0] value;
        pieces = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        for (int p = 0; p < pieces; p++) begin
            pick = $urandom_range(99);
            word = keyword_text[$urandom_range(KEYWORD_COUNT - 1)];
            if (pick < 45) begin
                add_text(word);
            end else if (pick < 55) begin
                if (word.len() > 1) begin
                    add_text(word.substr(0, word.len() - 2));
                end
            end else if (pick < 80) begin
                buffer_bytes.push_back(8'($urandom_range(32, 126)));
            end else begin
                value = 8'($urandom_range(1, 255));
                buffer_bytes.push_back(value == NEWLINE ? 8'h0D : value);
            end
        end
    endfunction

    function automatic void build_buffer();
        int   kind;
        int   lines;
        int   pick;
        logic [7:0] value;
        buffer_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 4) begin
            // Nothing but zero bytes.
            repeat ($urandom_range(1, 4)) buffer_bytes.push_back(ZERO_BYTE);
        end else if (kind < 10) begin
            // Raw noise rich in zero and newline bytes.
            repeat ($urandom_range(1, 16)) begin
                pick  = $urandom_range(99);
                value = 8'($urandom_range(0, 255));
                if (pick < 25) begin
                    value = ZERO_BYTE;
                end else if (pick < 40) begin
                    value = NEWLINE;
                end
                buffer_bytes.push_back(value);
            end
        end else begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 3)) buffer_bytes.push_back(ZERO_BYTE);
            end
            lines = $urandom_range(1, 4);
            for (int n = 0; n < lines; n++) begin
                add_line_body();
                if (n < lines - 1 || $urandom_range(1) == 1) begin
                    buffer_bytes.push_back(NEWLINE);
                end
            end
            // Text cut short by a zero byte, with a tail that must be ignored.
            if ($urandom_range(9) == 0) begin
                buffer_bytes.push_back(ZERO_BYTE);
                repeat ($urandom_range(1, 5)) buffer_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if (buffer_bytes.size() == 0) begin
                buffer_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
    endfunction

    initial begin
        int target;
        keyword_text[0] = "CONNECT";
        keyword_text[1] = "OK";
        keyword_text[2] = "ERROR";
        keyword_text[3] = "busy";
        keyword_text[4] = "AT";
        keyword_text[5] = {"SEND_FROM", "_PC"};
        keyword_text[6] = {"CIPSEND", "_PC"};
        keyword_text[7] = ">";
        keyword_text[8] = "CLOSED";
        keyword_text[9] = {"READ_BME", "280"};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Leading zero, a keyword line, an empty line, and two keywords at buffer end.
        buffer_bytes.delete();
        buffer_bytes.push_back(ZERO_BYTE);
        add_text("OK");
        buffer_bytes.push_back(NEWLINE);
        buffer_bytes.push_back(NEWLINE);
        add_text(">AT");
        send_buffer();

        // A buffer of zero bytes only.
        buffer_bytes.delete();
        buffer_bytes.push_back(ZERO_BYTE);
        buffer_bytes.push_back(ZERO_BYTE);
        send_buffer();

        // A zero byte stops the text; the rest, newline included, is ignored.
        buffer_bytes.delete();
        add_text("x");
        buffer_bytes.push_back(ZERO_BYTE);
        add_text("OK");
        buffer_bytes.push_back(NEWLINE);
        send_buffer();

        // Text ends on a newline before the final byte, which leaves nothing open.
        buffer_bytes.delete();
        buffer_bytes.push_back(8'hFF);
        buffer_bytes.push_back(NEWLINE);
        buffer_bytes.push_back(ZERO_BYTE);
        send_buffer();

        // A lone newline as the whole buffer.
        buffer_bytes.delete();
        buffer_bytes.push_back(NEWLINE);
        send_buffer();

        // Unknown text closed only by buffer end.
        buffer_bytes.delete();
        buffer_bytes.push_back(8'h80);
        buffer_bytes.push_back(8'h7F);
        send_buffer();

        // Random buffers under each idle and stall pattern.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
                default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
            endcase
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target) begin
                build_buffer();
                send_buffer();
            end
        end
        s_tvalid <= 1'b0;

        while (pending_lines != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d bytes in %0d receive buffers over four handshake patterns.",
                 bytes_sent, buffers_sent);
        $display("Checked %0d line codes, %0d mismatches.", lines_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS at_response_line_classifier");
        end else begin
            $display("FAIL at_response_line_classifier");
        end
        $finish;
    end

endmodule
